// ===== design/mmss_pkg.sv =====
// Shared types, request and status codes, and digit helpers for the mm:ss countdown timer.
// Used by the digit cell and the timer core; depends on nothing else.
`timescale 1ns / 1ps

package mmss_pkg;

   localparam int SecsPerMin = 60;

   // Request codes carried in req_tuser.
   localparam logic [2:0] REQ_TICK    = 3'd0;
   localparam logic [2:0] REQ_SET     = 3'd1;
   localparam logic [2:0] REQ_START   = 3'd2;
   localparam logic [2:0] REQ_PAUSE   = 3'd3;
   localparam logic [2:0] REQ_STOP    = 3'd4;
   localparam logic [2:0] REQ_CLEAR   = 3'd5;

   // Status codes of a result word.
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_RANGE   = 2'd1;
   localparam logic [1:0] STATUS_DIVIDER = 2'd2;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd3;

   // Highest value each digit position may hold.
   localparam logic [3:0] MAX_ONES = 4'd9;
   localparam logic [3:0] MAX_TENS = 4'd5;

   // Segment patterns for 0..9 before inversion to active low.
   localparam logic [7:0] SEG_PATTERN [10] = '{
      8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6
   };

   typedef struct packed {
      logic set_load;   // load both count and preset digit from a set word
      logic reload;     // copy the preset digit back into the count
   } cell_ctrl_type;

   function automatic logic [7:0] seg_code(input logic [3:0] d);
      logic [3:0] idx;
      idx = (d > 4'd9) ? 4'd9 : d;
      return ~SEG_PATTERN[idx];
   endfunction

   // Tens digit of a 7-bit value by reciprocal multiply; exact below 180.
   function automatic logic [3:0] tens_of(input logic [6:0] v);
      logic [17:0] prod;
      prod = 18'(v) * 18'd205;
      return prod[14:11];
   endfunction

   function automatic logic [3:0] ones_of(input logic [6:0] v);
      logic [6:0] tens10;
      tens10 = 7'(tens_of(v)) * 7'd10;
      return 4'(v - tens10);
   endfunction

   function automatic logic [11:0] digits_to_seconds(input logic [3:0] mt, input logic [3:0] mo,
                                                     input logic [3:0] st, input logic [3:0] so);
      logic [6:0]  mins;
      logic [6:0]  secs;
      mins = 7'(mt) * 7'd10 + 7'(mo);
      secs = 7'(st) * 7'd10 + 7'(so);
      return 12'(mins) * 12'(SecsPerMin) + 12'(secs);
   endfunction

endpackage

// ===== design/mmss_digit_cell.sv =====
// One decimal digit of the countdown: holds the live digit and its preset digit.
// A borrow enters from the lower neighbour and leaves towards the higher one. Uses mmss_pkg.
`timescale 1ns / 1ps

module mmss_digit_cell
   import mmss_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic [3:0]    set_digit,
   input  logic [3:0]    max_digit,
   input  logic [3:0]    reset_digit,
   input  logic          borrow_in,
   output logic [3:0]    digit,
   output logic [3:0]    next_digit,
   output logic          borrow_out,
   output logic [7:0]    seg_byte
);

   logic [3:0] digit_ff, digit_in;
   logic [3:0] preset_ff, preset_in;

   always_comb begin
      digit_in   = digit_ff;
      preset_in  = preset_ff;
      borrow_out = 1'b0;
      if (ctrl.set_load) begin
         digit_in  = set_digit;
         preset_in = set_digit;
      end else if (ctrl.reload) begin
         digit_in = preset_ff;
      end else if (borrow_in) begin
         // A zero digit wraps to its maximum and passes the borrow on.
         if (digit_ff == 4'd0) begin
            digit_in   = max_digit;
            borrow_out = 1'b1;
         end else begin
            digit_in = digit_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff  <= reset_digit;
         preset_ff <= reset_digit;
      end else begin
         digit_ff  <= digit_in;
         preset_ff <= preset_in;
      end
   end

   assign digit      = digit_ff;
   assign next_digit = digit_in;
   assign seg_byte   = seg_code(digit_in);

endmodule

// ===== design/mmss_countdown_timer_core.sv =====
// Top level of the mm:ss countdown timer: request decode, run and alarm flags,
// a row of four digit cells and the result register. Uses mmss_pkg and mmss_digit_cell.
// The result word of an accepted request word is registered and appears on rsp_ in the next cycle.
// One word per cycle unless rsp_ stalls; a decrement ripples through the four cells in that cycle.
// req_tready stays high while the result register is empty or being drained.
// Synchronous reset loads a count and preset of 01:00 with the timer halted and no alarm.
`timescale 1ns / 1ps

module mmss_countdown_timer_core
   import mmss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [6:0] set_minutes, [13:7] set_seconds, [14] divider_ok, [15] zero
   input  logic [15:0] req_tdata,
   // [2:0] req_type
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] status, [13:2] remaining_seconds, [16:14] minute_tens, [20:17] minute_ones,
   // [23:21] second_tens, [27:24] second_ones, [59:28] segment_bytes, [60] running,
   // [61] alarm_on, [62] tick_report_valid, [74:63] tick_report_value, [79:75] zero
   output logic [79:0] rsp_tdata
);

   localparam int NumCells = 4;

   logic          accept;
   logic [6:0]    set_minutes, set_seconds;
   logic          divider_ok;
   logic          run_ff, run_in;
   logic          alarm_ff, alarm_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [79:0]   rsp_data_ff, rsp_data_in;
   logic [1:0]    status;
   logic          rep_valid;
   logic          decrement;
   logic          next_zero;
   cell_ctrl_type ctrl;

   // Cell 0 is second ones, cell 3 is minute tens; borrows run upwards.
   logic [3:0] cell_digit [NumCells];
   logic [3:0] cell_next  [NumCells];
   logic [3:0] cell_set   [NumCells];
   logic [3:0] cell_max   [NumCells];
   logic [3:0] cell_rst   [NumCells];
   logic [7:0] cell_seg   [NumCells];
   logic       borrow     [NumCells+1];

   assign set_minutes = req_tdata[6:0];
   assign set_seconds = req_tdata[13:7];
   assign divider_ok  = req_tdata[14];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign cell_set[0] = ones_of(set_seconds);
   assign cell_set[1] = tens_of(set_seconds);
   assign cell_set[2] = ones_of(set_minutes);
   assign cell_set[3] = tens_of(set_minutes);
   assign cell_max[0] = MAX_ONES;
   assign cell_max[1] = MAX_TENS;
   assign cell_max[2] = MAX_ONES;
   assign cell_max[3] = MAX_TENS;
   assign cell_rst[0] = 4'd0;
   assign cell_rst[1] = 4'd0;
   assign cell_rst[2] = 4'd1;
   assign cell_rst[3] = 4'd0;

   // The count saturates at zero, so no borrow enters when it is already zero.
   assign decrement = accept && (req_tuser == REQ_TICK) && run_ff &&
                      ((cell_digit[0] | cell_digit[1] | cell_digit[2] | cell_digit[3]) != 4'd0);
   assign borrow[0] = decrement;

   for (genvar i = 0; i < NumCells; i++) begin : g_cell
      mmss_digit_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .set_digit   (cell_set[i]),
         .max_digit   (cell_max[i]),
         .reset_digit (cell_rst[i]),
         .borrow_in   (borrow[i]),
         .digit       (cell_digit[i]),
         .next_digit  (cell_next[i]),
         .borrow_out  (borrow[i+1]),
         .seg_byte    (cell_seg[i])
      );
   end

   assign next_zero = (cell_next[0] | cell_next[1] | cell_next[2] | cell_next[3]) == 4'd0;

   always_comb begin
      run_in        = run_ff;
      alarm_in      = alarm_ff;
      status        = STATUS_OK;
      rep_valid     = 1'b0;
      ctrl.set_load = 1'b0;
      ctrl.reload   = 1'b0;
      unique case (req_tuser)
         REQ_TICK: begin
            if (run_ff) begin
               rep_valid = 1'b1;
               if (next_zero) begin
                  run_in   = 1'b0;
                  alarm_in = 1'b1;
               end
            end
         end
         REQ_SET: begin
            if (!divider_ok) begin
               status = STATUS_DIVIDER;
            end else if (set_minutes < 7'(SecsPerMin) && set_seconds < 7'(SecsPerMin)) begin
               ctrl.set_load = accept;
               run_in        = 1'b1;
            end else begin
               status = STATUS_RANGE;
            end
         end
         REQ_START: run_in = 1'b1;
         REQ_PAUSE: run_in = 1'b0;
         REQ_STOP: begin
            ctrl.reload = accept;
            run_in      = 1'b0;
         end
         REQ_CLEAR: alarm_in = 1'b0;
         default:   status = STATUS_UNKNOWN;
      endcase
   end

   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in[1:0]   = status;
      rsp_data_in[13:2]  = digits_to_seconds(cell_next[3], cell_next[2],
                                             cell_next[1], cell_next[0]);
      rsp_data_in[16:14] = cell_next[3][2:0];
      rsp_data_in[20:17] = cell_next[2];
      rsp_data_in[23:21] = cell_next[1][2:0];
      rsp_data_in[27:24] = cell_next[0];
      // Display digit 0 is minute tens, digit 3 is second ones.
      rsp_data_in[59:28] = {cell_seg[0], cell_seg[1], cell_seg[2], cell_seg[3]};
      rsp_data_in[60]    = run_in;
      rsp_data_in[61]    = alarm_in;
      rsp_data_in[62]    = rep_valid;
      if (rep_valid) begin
         rsp_data_in[74:63] = digits_to_seconds(cell_digit[3], cell_digit[2],
                                                cell_digit[1], cell_digit[0]);
      end
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         alarm_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            run_ff   <= run_in;
            alarm_ff <= alarm_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A reported tick is one above the count left, or zero when it has saturated.
   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[62]) |->
         ((rsp_data_ff[74:63] == rsp_data_ff[13:2] + 12'd1) ||
          (rsp_data_ff[74:63] == 12'd0 && rsp_data_ff[13:2] == 12'd0)))
      else $error("tick report does not match the remaining count");

   // Reaching zero on a tick halts the timer and raises the alarm.
   a_zero_alarm: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[62] && rsp_data_ff[13:2] == 12'd0) |->
         (!rsp_data_ff[60] && rsp_data_ff[61]))
      else $error("count reached zero without halting and raising the alarm");

   // The tens cells never leave the range 0 to 5.
   a_tens_range: assert property (@(posedge clock) disable iff (reset)
      (cell_digit[1] <= MAX_TENS) && (cell_digit[3] <= MAX_TENS))
      else $error("tens digit out of range");

   // Every accepted request word yields a result word in the next cycle.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no result");

endmodule

// ===== tb/sv/mmss_timer_monitor.sv =====
`timescale 1ns / 1ps
// Watches the request and result streams of the mm:ss countdown timer, predicts each
// result word from its own model of the timer and compares them field by field.
// Depends on mmss_pkg for the request and status codes.

module mmss_timer_monitor
   import mmss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [79:0] rsp_tdata,
   output int unsigned mismatches,
   output int unsigned pending_count,
   output int unsigned words_checked,
   output int unsigned tick_reports,
   output int unsigned rejected_requests
);

   localparam int unsigned SECS_IN_MINUTE = 60;

   // Lit segments for 0..9; the display drives them active low.
   localparam logic [7:0] DIGIT_GLYPH [10] = '{
      8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6
   };

   typedef struct {
      logic [1:0]  status;
      logic [11:0] remaining;
      logic [2:0]  min_tens;
      logic [3:0]  min_ones;
      logic [2:0]  sec_tens;
      logic [3:0]  sec_ones;
      logic [31:0] segments;
      logic        running;
      logic        alarm;
      logic        report_valid;
      logic [11:0] report_value;
   } timer_view_type;

   timer_view_type expected_views [$];

   logic [11:0] preset_secs;
   logic [11:0] count_secs;
   logic        counting;
   logic        alarm_raised;

   function automatic logic [7:0] segment_byte(input int unsigned digit);
      return ~DIGIT_GLYPH[digit];
   endfunction

   // Applies one request word to the timer model and returns the display it leaves.
   function automatic timer_view_type apply_request(input logic [2:0] kind,
                                                    input logic [6:0] mins,
                                                    input logic [6:0] secs,
                                                    input logic divider);
      timer_view_type view;
      int unsigned mins_left;
      int unsigned secs_left;
      view.status = STATUS_OK;
      view.report_valid = 1'b0;
      view.report_value = '0;
      case (kind)
         REQ_TICK: begin
            if (counting) begin
               view.report_valid = 1'b1;
               view.report_value = count_secs;
               // The count holds at zero rather than wrapping.
               if (count_secs != 0) count_secs = count_secs - 12'd1;
               if (count_secs == 0) begin
                  counting = 1'b0;
                  alarm_raised = 1'b1;
               end
            end
         end
         REQ_SET: begin
            if (!divider) begin
               view.status = STATUS_DIVIDER;
            end else if (mins < SECS_IN_MINUTE && secs < SECS_IN_MINUTE) begin
               preset_secs = 12'(mins * SECS_IN_MINUTE + secs);
               count_secs = preset_secs;
               counting = 1'b1;
            end else begin
               view.status = STATUS_RANGE;
            end
         end
         REQ_START: counting = 1'b1;
         REQ_PAUSE: counting = 1'b0;
         REQ_STOP: begin
            count_secs = preset_secs;
            counting = 1'b0;
         end
         REQ_CLEAR: alarm_raised = 1'b0;
         default: view.status = STATUS_UNKNOWN;
      endcase
      mins_left = count_secs / SECS_IN_MINUTE;
      secs_left = count_secs % SECS_IN_MINUTE;
      view.remaining = count_secs;
      view.min_tens = 3'(mins_left / 10);
      view.min_ones = 4'(mins_left % 10);
      view.sec_tens = 3'(secs_left / 10);
      view.sec_ones = 4'(secs_left % 10);
      view.segments = {segment_byte(secs_left % 10), segment_byte(secs_left / 10),
                       segment_byte(mins_left % 10), segment_byte(mins_left / 10)};
      view.running = counting;
      view.alarm = alarm_raised;
      return view;
   endfunction

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      timer_view_type seen;
      timer_view_type want;
      if (reset) begin
         expected_views.delete();
         preset_secs = 12'd60;
         count_secs = 12'd60;
         counting = 1'b0;
         alarm_raised = 1'b0;
      end else begin
         // A result word answers an earlier request, so it is matched before this
         // edge's request is predicted.
         if (rsp_tvalid && rsp_tready) begin
            seen.status = rsp_tdata[1:0];
            seen.remaining = rsp_tdata[13:2];
            seen.min_tens = rsp_tdata[16:14];
            seen.min_ones = rsp_tdata[20:17];
            seen.sec_tens = rsp_tdata[23:21];
            seen.sec_ones = rsp_tdata[27:24];
            seen.segments = rsp_tdata[59:28];
            seen.running = rsp_tdata[60];
            seen.alarm = rsp_tdata[61];
            seen.report_valid = rsp_tdata[62];
            seen.report_value = rsp_tdata[74:63];
            if (expected_views.size() == 0) begin
               $error("result word arrived with no request outstanding");
               mismatches++;
            end else begin
               want = expected_views.pop_front();
               compare_field("status", want.status, seen.status);
               compare_field("remaining_seconds", want.remaining, seen.remaining);
               compare_field("minute_tens", want.min_tens, seen.min_tens);
               compare_field("minute_ones", want.min_ones, seen.min_ones);
               compare_field("second_tens", want.sec_tens, seen.sec_tens);
               compare_field("second_ones", want.sec_ones, seen.sec_ones);
               compare_field("segment_bytes", want.segments, seen.segments);
               compare_field("running", want.running, seen.running);
               compare_field("alarm_on", want.alarm, seen.alarm);
               compare_field("tick_report_valid", want.report_valid, seen.report_valid);
               compare_field("tick_report_value", want.report_value, seen.report_value);
               words_checked++;
               if (want.report_valid) tick_reports++;
               if (want.status != STATUS_OK) rejected_requests++;
            end
         end
         if (req_tvalid && req_tready) begin
            expected_views.push_back(apply_request(req_tuser, req_tdata[6:0],
                                                   req_tdata[13:7], req_tdata[14]));
         end
      end
      pending_count = expected_views.size();
   end

endmodule

// ===== tb/sv/mmss_countdown_timer_core_tb.sv =====
`timescale 1ns / 1ps
// Top of the countdown timer bench: clock, reset, request stimulus and result back-pressure.
// Depends on mmss_pkg, mmss_countdown_timer_core and mmss_timer_monitor.

module mmss_countdown_timer_core_tb
   import mmss_pkg::*;
();

   // Codes the block must reject as unknown commands.
   localparam logic [2:0] REQ_UNKNOWN = 3'd6;
   localparam logic [2:0] REQ_SPARE   = 3'd7;

   localparam int RANDOM_PER_PHASE = 260;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;

   int unsigned mismatches;
   int unsigned pending_count;
   int unsigned words_checked;
   int unsigned tick_reports;
   int unsigned rejected_requests;

   int unsigned tx_idle_pct;
   int unsigned rx_stall_pct;

   mmss_countdown_timer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   mmss_timer_monitor monitor (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .mismatches        (mismatches),
      .pending_count     (pending_count),
      .words_checked     (words_checked),
      .tick_reports      (tick_reports),
      .rejected_requests (rejected_requests)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      rsp_tready = 1'b0;
      rx_stall_pct = 67;
   end

   always @(negedge clock) begin
      rsp_tready = reset ? 1'b0 : ($urandom_range(99) >= rx_stall_pct);
   end

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_request(input logic [2:0] kind, input logic [6:0] mins,
                               input logic [6:0] secs, input logic divider);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = kind;
      req_tdata = {1'b0, divider, secs, mins};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic await_results();
      req_tvalid = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Mostly short set-and-tick runs so that the count regularly reaches zero.
   task automatic send_random_request();
      int unsigned pick;
      int unsigned shape;
      logic [2:0]  kind;
      logic [6:0]  mins;
      logic [6:0]  secs;
      logic        divider;
      pick = $urandom_range(99);
      mins = 7'($urandom_range(127));
      secs = 7'($urandom_range(127));
      divider = 1'($urandom_range(1));
      if (pick < 50) kind = REQ_TICK;
      else if (pick < 66) kind = REQ_SET;
      else if (pick < 74) kind = REQ_START;
      else if (pick < 81) kind = REQ_PAUSE;
      else if (pick < 88) kind = REQ_STOP;
      else if (pick < 95) kind = REQ_CLEAR;
      else kind = $urandom_range(1) ? REQ_UNKNOWN : REQ_SPARE;
      if (kind == REQ_SET) begin
         shape = $urandom_range(99);
         if (shape < 60) begin
            mins = 7'd0;
            secs = 7'($urandom_range(5));
         end else if (shape < 80) begin
            mins = 7'($urandom_range(59));
            secs = 7'($urandom_range(59));
         end
         divider = ($urandom_range(99) < 90);
      end
      send_request(kind, mins, secs, divider);
      if ($urandom_range(63) == 0) await_results();
   endtask

   task automatic run_directed();
      send_request(REQ_TICK, 7'd0, 7'd0, 1'b0);       // tick while halted
      send_request(REQ_START, 7'd0, 7'd0, 1'b0);
      send_request(REQ_TICK, 7'd0, 7'd0, 1'b0);
      send_request(REQ_PAUSE, 7'd0, 7'd0, 1'b0);
      send_request(REQ_TICK, 7'd0, 7'd0, 1'b0);
      send_request(REQ_STOP, 7'd0, 7'd0, 1'b0);
      send_request(REQ_SET, 7'd127, 7'd127, 1'b0);    // divider missing wins over range
      send_request(REQ_SET, 7'd60, 7'd0, 1'b1);
      send_request(REQ_SET, 7'd0, 7'd60, 1'b1);
      send_request(REQ_SET, 7'd127, 7'd127, 1'b1);
      send_request(REQ_SET, 7'd59, 7'd59, 1'b1);
      send_request(REQ_TICK, 7'd0, 7'd0, 1'b0);
      send_request(REQ_SET, 7'd10, 7'd0, 1'b1);       // borrow across every digit
      send_request(REQ_TICK, 7'd0, 7'd0, 1'b0);
      send_request(REQ_SET, 7'd0, 7'd0, 1'b1);        // zero time, then tick raises alarm
      send_request(REQ_TICK, 7'd0, 7'd0, 1'b0);
      send_request(REQ_TICK, 7'd0, 7'd0, 1'b0);
      send_request(REQ_SET, 7'd0, 7'd1, 1'b1);        // alarm survives a set
      send_request(REQ_TICK, 7'd0, 7'd0, 1'b0);
      send_request(REQ_START, 7'd0, 7'd0, 1'b0);      // start with nothing left
      send_request(REQ_TICK, 7'd0, 7'd0, 1'b0);
      send_request(REQ_CLEAR, 7'd0, 7'd0, 1'b0);
      send_request(REQ_UNKNOWN, 7'd0, 7'd0, 1'b0);
      send_request(REQ_SPARE, 7'd127, 7'd127, 1'b1);
      send_request(REQ_STOP, 7'd0, 7'd0, 1'b0);
   endtask

   initial begin : stimulus
      int phase;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = REQ_TICK;
      tx_idle_pct = 18;
      repeat (12) @(negedge clock);
      reset = 1'b0;
      run_directed();
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               tx_idle_pct = 18;
               rx_stall_pct = 67;
            end
            1: begin
               tx_idle_pct = 67;
               rx_stall_pct = 18;
            end
            default: begin
               tx_idle_pct = 0;
               rx_stall_pct = 0;
            end
         endcase
         repeat (RANDOM_PER_PHASE) send_random_request();
         await_results();
      end
      repeat (4) @(negedge clock);
      $display("Checked %0d result words: %0d tick reports, %0d rejected requests.",
               words_checked, tick_reports, rejected_requests);
      $display("Idle patterns ran sender-heavy, receiver-heavy and back to back.");
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Run timed out with %0d result words outstanding.", pending_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
